>>> sv/s2a_pkg.sv
// Shared types, key numbers and the set-1 code table for the scancode decoder.
// No dependencies; s2a_decode, scancode_to_ascii and the testbench import this package.
package s2a_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 89;
    localparam int KEY_TABLE_DEPTH       = 89;

    localparam logic [7:0] RELEASE_MASK  = 8'h80;
    localparam logic [7:0] KEY_MASK      = 8'h7F;
    localparam logic [7:0] PREFIX_EXT    = 8'hE0;
    localparam logic [7:0] PREFIX_PAUSE  = 8'hE1;
    localparam logic [7:0] PAUSE_CODE    = 8'hA0;
    localparam logic [1:0] PAUSE_SKIP_BYTES = 2'd2;

    localparam logic [6:0] KEY_LEFT_SHIFT  = 7'd42;
    localparam logic [6:0] KEY_RIGHT_SHIFT = 7'd54;
    localparam logic [6:0] KEY_CAPS      = 7'd58;
    localparam logic [6:0] KEY_NUM       = 7'd69;
    localparam logic [6:0] KEY_SCROLL    = 7'd70;
    localparam logic [6:0] KEY_SPACE     = 7'd57;
    localparam logic [6:0] SHIFT_FIRST   = 7'd2;
    localparam logic [6:0] SHIFT_LAST    = 7'd53;
    localparam logic [6:0] NUMPAD_FIRST  = 7'd71;
    localparam logic [6:0] NUMPAD_LAST   = 7'd83;

    localparam logic [7:0] LETTER_FIRST  = 8'h61;
    localparam logic [7:0] LETTER_LAST   = 8'h7A;

    // Each entry is {shifted, normal}.
    localparam logic [15:0] KEY_TABLE [KEY_TABLE_DEPTH] = '{
        16'h0000, 16'h1B1B, 16'h2131, 16'h4032, 16'h2333, 16'h2434, 16'h2535, 16'h5E36,
        16'h2637, 16'h2A38, 16'h2839, 16'h2930, 16'h5F2D, 16'h2B3D, 16'h0808, 16'h0909,
        16'h5171, 16'h5777, 16'h4565, 16'h5272, 16'h5474, 16'h5979, 16'h5575, 16'h4969,
        16'h4F6F, 16'h5070, 16'h7B5B, 16'h7D5D, 16'h0A0A, 16'h8181, 16'h4161, 16'h5373,
        16'h4464, 16'h4666, 16'h4767, 16'h4868, 16'h4A6A, 16'h4B6B, 16'h4C6C, 16'h3A3B,
        16'h2227, 16'h7E60, 16'h8282, 16'h7C5C, 16'h5A7A, 16'h5878, 16'h4363, 16'h5676,
        16'h4262, 16'h4E6E, 16'h4D6D, 16'h3C2C, 16'h3E2E, 16'h3F2F, 16'h8383, 16'h2A2A,
        16'h8585, 16'h2020, 16'h8686, 16'h8787, 16'h8888, 16'h8989, 16'h8A8A, 16'h8B8B,
        16'h8C8C, 16'h8D8D, 16'h8E8E, 16'h8F8F, 16'h9090, 16'h9191, 16'h9292, 16'h3793,
        16'h3894, 16'h3995, 16'h2D2D, 16'h3496, 16'h3597, 16'h3698, 16'h2B2B, 16'h3199,
        16'h329A, 16'h339B, 16'h309C, 16'h2E9D, 16'h0000, 16'h0000, 16'h0000, 16'h9E9E,
        16'h9F9F
    };

    typedef struct packed {
        logic       shift_held;
        logic       caps_lock;
        logic       num_lock;
        logic       scroll_lock;
        logic       extended_pending;
        logic [1:0] pause_skip;
    } kbd_state_t;

    typedef struct packed {
        logic       char_valid;
        logic [7:0] char_code;
        logic       led_update;
        logic [2:0] led_state;
    } char_result_t;

    function automatic logic [15:0] key_lookup(input logic [6:0] key);
        logic [15:0] entry;
        entry = 16'h0000;
        if ({1'b0, key} < 8'(KEY_TABLE_DEPTH))
        begin
            entry = KEY_TABLE[key];
        end
        return entry;
    endfunction

endpackage

>>> sv/s2a_if.sv
// Valid/ready channel interfaces for scancode bytes in and decoded characters out.
// No dependencies.
interface s2a_scan_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_byte;

    modport source (output valid, output scan_byte, input ready);
    modport sink   (input valid, input scan_byte, output ready);
endinterface

interface s2a_char_if;
    logic       valid;
    logic       ready;
    logic       char_valid;
    logic [7:0] char_code;
    logic       led_update;
    logic [2:0] led_state;

    modport source (output valid, output char_valid, output char_code,
                    output led_update, output led_state, input ready);
    modport sink   (input valid, input char_valid, input char_code,
                    input led_update, input led_state, output ready);
endinterface

>>> sv/s2a_decode.sv
// Combinational decode of one scancode byte against the keyboard flags.
// Depends on s2a_pkg for the code table, key numbers and state/result types.
module s2a_decode
    import s2a_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
)
(
    input  logic [7:0]   scan_byte,
    input  kbd_state_t   state,
    output kbd_state_t   state_next,
    output char_result_t result
);

    localparam logic [7:0] TableLimit = 8'(TABLE_ENTRIES);

    logic [6:0]  key;
    logic [15:0] entry;
    logic [7:0]  normal;
    logic [7:0]  shifted;

    assign key     = 7'(scan_byte & KEY_MASK);
    assign entry   = key_lookup(key);
    assign normal  = entry[7:0];
    assign shifted = entry[15:8];

    always_comb
    begin
        state_next = state;
        result     = '0;

        priority if (state.pause_skip != 2'd0)
        begin
            // swallow the trailing pause bytes
            state_next.pause_skip = state.pause_skip - 2'd1;
        end
        else if (!state.extended_pending && scan_byte == PREFIX_PAUSE)
        begin
            state_next.pause_skip = PAUSE_SKIP_BYTES;
            result.char_valid     = 1'b1;
            result.char_code      = PAUSE_CODE;
        end
        else if (!state.extended_pending && scan_byte == PREFIX_EXT)
        begin
            state_next.extended_pending = 1'b1;
        end
        else
        begin
            state_next.extended_pending = 1'b0;
            priority if ((scan_byte & RELEASE_MASK) != 8'h00)
            begin
                if (key == KEY_LEFT_SHIFT || key == KEY_RIGHT_SHIFT)
                begin
                    state_next.shift_held = 1'b0;
                end
            end
            else if (key == KEY_LEFT_SHIFT || key == KEY_RIGHT_SHIFT)
            begin
                state_next.shift_held = 1'b1;
            end
            else if (key == KEY_CAPS)
            begin
                state_next.caps_lock = ~state.caps_lock;
                result.led_update    = 1'b1;
            end
            else if (key == KEY_NUM)
            begin
                state_next.num_lock = ~state.num_lock;
                result.led_update   = 1'b1;
            end
            else if (key == KEY_SCROLL)
            begin
                state_next.scroll_lock = ~state.scroll_lock;
                result.led_update      = 1'b1;
            end
            else if ({1'b0, key} < TableLimit)
            begin
                priority if (normal >= LETTER_FIRST && normal <= LETTER_LAST)
                begin
                    result.char_valid = 1'b1;
                    result.char_code  = (state.shift_held | state.caps_lock) ? shifted : normal;
                end
                else if (key >= SHIFT_FIRST && key <= SHIFT_LAST)
                begin
                    result.char_valid = 1'b1;
                    result.char_code  = state.shift_held ? shifted : normal;
                end
                else if (key >= NUMPAD_FIRST && key <= NUMPAD_LAST)
                begin
                    result.char_valid = 1'b1;
                    result.char_code  = state.num_lock ? shifted : normal;
                end
                else if (key == KEY_SPACE)
                begin
                    result.char_valid = 1'b1;
                    result.char_code  = normal;
                end
                else
                begin
                    result.char_valid = 1'b0;
                end
            end
            else
            begin
                result.char_valid = 1'b0;
            end
        end

        // LEDs always show the flags as they stand after this byte
        result.led_state = {state_next.caps_lock, state_next.num_lock, state_next.scroll_lock};
    end

endmodule

>>> sv/scancode_to_ascii.sv
// Set-1 scancode to character decoder, top level: input and result registers.
// Depends on s2a_pkg, s2a_if (channel interfaces) and s2a_decode.
//
// Usage:
//   scan_in  carries one raw scancode byte per transaction (valid/ready).
//   char_out carries one result per input byte: char_valid and char_code for
//   a pressed character key or the pause prefix, led_update when a lock key
//   toggled, and led_state {caps, num, scroll} after the byte.
//   Every accepted byte yields exactly one result transaction, in order.
// Path: a byte accepted on scan_in passes through two register stages
//   (input register, then result register) before it is presented on char_out.
// Throughput: one byte per cycle while char_out is ready; the decode is a single
//   table lookup and flag update between the two registers, and the flags feed
//   back in the same cycle.
// Stall: while char_out is not ready the result register holds; the input
//   register still takes one more byte, then scan_in.ready drops.
// Reset: rst_n low clears both registers' valid flags and all flags (shift,
//   locks, prefix and pause skip); the code table is constant.
module scancode_to_ascii
    import s2a_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT
)
(
    input  logic          clk,
    input  logic          rst_n,
    s2a_scan_if.sink      scan_in,
    s2a_char_if.source    char_out
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    char_result_t out_res_reg;
    kbd_state_t   state_reg;

    kbd_state_t   state_next;
    char_result_t res_next;
    logic         advance;

    s2a_decode #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_decode (
        .scan_byte  (in_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    // move the held byte into the result register when it is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || char_out.ready);
    assign scan_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (scan_in.ready)
            begin
                in_valid_reg <= scan_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (char_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_in.valid && scan_in.ready)
        begin
            in_byte_reg <= scan_in.scan_byte;
        end
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    assign char_out.valid      = out_valid_reg;
    assign char_out.char_valid = out_res_reg.char_valid;
    assign char_out.char_code  = out_res_reg.char_code;
    assign char_out.led_update = out_res_reg.led_update;
    assign char_out.led_state  = out_res_reg.led_state;

`ifndef SYNTHESIS
    a_advance_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("decoded transaction did not reach the result register");

    a_state_holds_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("keyboard flags changed without a decoded byte");

    a_prefix_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg.extended_pending && state_reg.pause_skip != 2'd0))
        else $error("extended prefix pending while skipping pause bytes");

    a_pause_arms_skip: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_byte_reg == PREFIX_PAUSE && state_reg.pause_skip == 2'd0
            && !state_reg.extended_pending
        |=> state_reg.pause_skip == PAUSE_SKIP_BYTES && out_res_reg.char_valid)
        else $error("pause prefix did not arm the skip count");
`endif

endmodule

>>> verif/scancode_to_ascii_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for scancode_to_ascii: directed and random scancode traffic.
// Depends on s2a_pkg, scancode_to_ascii and the s2a_scan_if / s2a_char_if channel interfaces.
module scancode_to_ascii_tb;
    import s2a_pkg::*;

    localparam int TABLE_SIZE     = 89;
    localparam int DRAIN_CYCLES   = 8;
    localparam int RANDOM_PER_PHASE = 212;

    localparam logic [6:0] KEY_ESC    = 7'd1;
    localparam logic [6:0] KEY_1      = 7'd2;
    localparam logic [6:0] KEY_CONTROL = 7'd29;
    localparam logic [6:0] KEY_A      = 7'd30;
    localparam logic [6:0] KEY_KP7    = 7'd71;
    localparam logic [6:0] KEY_KP8    = 7'd72;
    localparam logic [6:0] KEY_KP_DEL = 7'd83;
    localparam logic [6:0] KEY_EMPTY  = 7'd84;

    // {shifted, normal} per key number
    localparam logic [15:0] SCAN_CODES [TABLE_SIZE] = '{
        16'h0000, 16'h1B1B, 16'h2131, 16'h4032, 16'h2333, 16'h2434, 16'h2535, 16'h5E36,
        16'h2637, 16'h2A38, 16'h2839, 16'h2930, 16'h5F2D, 16'h2B3D, 16'h0808, 16'h0909,
        16'h5171, 16'h5777, 16'h4565, 16'h5272, 16'h5474, 16'h5979, 16'h5575, 16'h4969,
        16'h4F6F, 16'h5070, 16'h7B5B, 16'h7D5D, 16'h0A0A, 16'h8181, 16'h4161, 16'h5373,
        16'h4464, 16'h4666, 16'h4767, 16'h4868, 16'h4A6A, 16'h4B6B, 16'h4C6C, 16'h3A3B,
        16'h2227, 16'h7E60, 16'h8282, 16'h7C5C, 16'h5A7A, 16'h5878, 16'h4363, 16'h5676,
        16'h4262, 16'h4E6E, 16'h4D6D, 16'h3C2C, 16'h3E2E, 16'h3F2F, 16'h8383, 16'h2A2A,
        16'h8585, 16'h2020, 16'h8686, 16'h8787, 16'h8888, 16'h8989, 16'h8A8A, 16'h8B8B,
        16'h8C8C, 16'h8D8D, 16'h8E8E, 16'h8F8F, 16'h9090, 16'h9191, 16'h9292, 16'h3793,
        16'h3894, 16'h3995, 16'h2D2D, 16'h3496, 16'h3597, 16'h3698, 16'h2B2B, 16'h3199,
        16'h329A, 16'h339B, 16'h309C, 16'h2E9D, 16'h0000, 16'h0000, 16'h0000, 16'h9E9E,
        16'h9F9F
    };

    logic clk;
    logic rst_n;

    s2a_scan_if scan_in ();
    s2a_char_if char_out ();

    scancode_to_ascii u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .scan_in  (scan_in),
        .char_out (char_out)
    );

    // keyboard state tracked alongside the block
    logic       shift_on;
    logic       caps_on;
    logic       num_on;
    logic       scroll_on;
    logic       ext_pending;
    logic [1:0] skip_left;

    char_result_t expected_chars [$];
    int           mismatch_count;
    int           send_idle_pct;
    int           recv_stall_pct;

    function automatic char_result_t decode_scan(input logic [7:0] scan_b);
        char_result_t res;
        logic [6:0]   k;
        logic [15:0]  entry;
        logic [7:0]   nrm;
        logic [7:0]   shf;
        res = '0;
        k = scan_b[6:0];
        if (skip_left != 2'd0)
        begin
            skip_left = skip_left - 2'd1;
        end
        else if (!ext_pending && scan_b == PREFIX_PAUSE)
        begin
            skip_left = PAUSE_SKIP_BYTES;
            res.char_valid = 1'b1;
            res.char_code = PAUSE_CODE;
        end
        else if (!ext_pending && scan_b == PREFIX_EXT)
        begin
            ext_pending = 1'b1;
        end
        else
        begin
            // byte after an extended prefix is always a key, even another prefix
            ext_pending = 1'b0;
            if (scan_b[7])
            begin
                if (k == KEY_LEFT_SHIFT || k == KEY_RIGHT_SHIFT)
                    shift_on = 1'b0;
            end
            else if (k == KEY_LEFT_SHIFT || k == KEY_RIGHT_SHIFT)
            begin
                shift_on = 1'b1;
            end
            else if (k == KEY_CAPS)
            begin
                caps_on = ~caps_on;
                res.led_update = 1'b1;
            end
            else if (k == KEY_NUM)
            begin
                num_on = ~num_on;
                res.led_update = 1'b1;
            end
            else if (k == KEY_SCROLL)
            begin
                scroll_on = ~scroll_on;
                res.led_update = 1'b1;
            end
            else if (int'(k) < TABLE_SIZE)
            begin
                entry = SCAN_CODES[k];
                nrm = entry[7:0];
                shf = entry[15:8];
                if (nrm >= LETTER_FIRST && nrm <= LETTER_LAST)
                begin
                    res.char_valid = 1'b1;
                    res.char_code = (shift_on || caps_on) ? shf : nrm;
                end
                else if (k >= SHIFT_FIRST && k <= SHIFT_LAST)
                begin
                    res.char_valid = 1'b1;
                    res.char_code = shift_on ? shf : nrm;
                end
                else if (k >= NUMPAD_FIRST && k <= NUMPAD_LAST)
                begin
                    res.char_valid = 1'b1;
                    res.char_code = num_on ? shf : nrm;
                end
                else if (k == KEY_SPACE)
                begin
                    res.char_valid = 1'b1;
                    res.char_code = nrm;
                end
            end
        end
        res.led_state = {caps_on, num_on, scroll_on};
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #500000;
        $display("TEST FAILED");
        $finish;
    end

    // receiver side: random backpressure
    always @(negedge clk)
    begin
        char_out.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // predict on each input transaction, check each result transaction
    always @(posedge clk)
    begin
        char_result_t want;
        if (rst_n)
        begin
            if (char_out.valid && char_out.ready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected result transaction: char_code %h", char_out.char_code);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_out.char_valid !== want.char_valid)
                    begin
                        $error("char_valid: expected %b, got %b",
                               want.char_valid, char_out.char_valid);
                        mismatch_count++;
                    end
                    if (char_out.char_code !== want.char_code)
                    begin
                        $error("char_code: expected %h, got %h",
                               want.char_code, char_out.char_code);
                        mismatch_count++;
                    end
                    if (char_out.led_update !== want.led_update)
                    begin
                        $error("led_update: expected %b, got %b",
                               want.led_update, char_out.led_update);
                        mismatch_count++;
                    end
                    if (char_out.led_state !== want.led_state)
                    begin
                        $error("led_state: expected %b, got %b",
                               want.led_state, char_out.led_state);
                        mismatch_count++;
                    end
                end
            end
            if (scan_in.valid && scan_in.ready)
                expected_chars.push_back(decode_scan(scan_in.scan_byte));
        end
    end

    // Entered and left at a falling edge; valid stays high for back-to-back bytes.
    task automatic send_scan(input logic [7:0] scan_b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            scan_in.valid = 1'b0;
            scan_in.scan_byte = 8'($urandom);
            @(negedge clk);
        end
        scan_in.valid = 1'b1;
        scan_in.scan_byte = scan_b;
        @(posedge clk);
        while (!scan_in.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic tap_key(input logic [6:0] k);
        send_scan({1'b0, k});
        send_scan({1'b1, k});
    endtask

    // hold the sender until every outstanding result has come back
    task automatic wait_results_drained();
        scan_in.valid = 1'b0;
        while (expected_chars.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic test_key_extremes();
        send_scan(8'h00);
        send_scan(8'hFF);
        send_scan({1'b0, KEY_ESC});
        send_scan({1'b0, KEY_CONTROL});
        send_scan({1'b0, 7'(TABLE_SIZE)});
        send_scan({1'b0, KEY_EMPTY});
    endtask

    task automatic test_shift_and_caps();
        send_scan({1'b0, KEY_LEFT_SHIFT});
        send_scan({1'b0, KEY_A});
        send_scan({1'b0, KEY_1});
        send_scan({1'b1, KEY_LEFT_SHIFT});
        send_scan({1'b0, KEY_CAPS});
        send_scan({1'b0, KEY_A});
        send_scan({1'b0, KEY_CAPS});
    endtask

    task automatic test_numpad_and_locks();
        send_scan({1'b0, KEY_KP7});
        send_scan({1'b0, KEY_NUM});
        send_scan({1'b0, KEY_KP_DEL});
        send_scan({1'b0, KEY_SPACE});
        send_scan({1'b0, KEY_SCROLL});
        send_scan({1'b0, KEY_NUM});
    endtask

    task automatic test_prefixes();
        send_scan(PREFIX_EXT);
        send_scan({1'b0, KEY_KP8});
        // extended prefix followed by the pause prefix: taken as a key
        send_scan(PREFIX_EXT);
        send_scan(PREFIX_PAUSE);
        send_scan(PREFIX_PAUSE);
        send_scan({1'b0, KEY_CONTROL});
        send_scan({1'b0, KEY_NUM});
        send_scan(PREFIX_EXT);
        send_scan(PREFIX_EXT);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
        int         sent;
        int         pick;
        int         reps;
        logic [6:0] k;
        logic [6:0] shift_key;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n)
        begin
            pick = $urandom_range(99);
            k = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(1, 88));
            if (pick < 40)
            begin
                tap_key(k);
                sent += 2;
            end
            else if (pick < 55)
            begin
                shift_key = $urandom_range(1) ? KEY_LEFT_SHIFT : KEY_RIGHT_SHIFT;
                reps = $urandom_range(1, 3);
                send_scan({1'b0, shift_key});
                repeat (reps)
                    tap_key(7'($urandom_range(1, 88)));
                send_scan({1'b1, shift_key});
                sent += 2 + 2 * reps;
            end
            else if (pick < 65)
            begin
                case ($urandom_range(2))
                    0: tap_key(KEY_CAPS);
                    1: tap_key(KEY_NUM);
                    default: tap_key(KEY_SCROLL);
                endcase
                sent += 2;
            end
            else if (pick < 78)
            begin
                send_scan(PREFIX_EXT);
                send_scan({1'b0, k});
                send_scan(PREFIX_EXT);
                send_scan({1'b1, k});
                sent += 4;
            end
            else if (pick < 86)
            begin
                // full pause key sequence
                send_scan(PREFIX_PAUSE);
                send_scan({1'b0, KEY_CONTROL});
                send_scan({1'b0, KEY_NUM});
                send_scan(PREFIX_PAUSE);
                send_scan({1'b1, KEY_CONTROL});
                send_scan({1'b1, KEY_NUM});
                sent += 6;
            end
            else
            begin
                reps = $urandom_range(1, 3);
                repeat (reps)
                    send_scan(8'($urandom));
                sent += reps;
            end
        end
        wait_results_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        scan_in.valid = 1'b0;
        scan_in.scan_byte = 8'h00;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        shift_on = 1'b0;
        caps_on = 1'b0;
        num_on = 1'b0;
        scroll_on = 1'b0;
        ext_pending = 1'b0;
        skip_left = 2'd0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        recv_stall_pct = 30;
        test_key_extremes();
        test_shift_and_caps();
        test_numpad_and_locks();
        test_prefixes();
        wait_results_drained();

        test_random_traffic(0, 0, RANDOM_PER_PHASE);
        test_random_traffic(72, 0, RANDOM_PER_PHASE);
        test_random_traffic(0, 72, RANDOM_PER_PHASE);
        test_random_traffic(22, 22, RANDOM_PER_PHASE);

        if (mismatch_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
